// ----- design/otq_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// otq_pkg: shared types and constants of the ordered timer expiry queue
// Field layouts of the input and result transactions, opcode names and the
// command/status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package otq_pkg;

  localparam int NUM_TIMERS  = 16;
  localparam int IDX_W       = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int STAMP_W     = IDX_W;
  localparam int CNT_W       = $clog2(NUM_TIMERS + 1);
  localparam int MAX_RESULTS = 16;
  localparam int RIDX_W      = $clog2(MAX_RESULTS);
  localparam int RES_W       = $clog2(MAX_RESULTS + 1);

  localparam int OP_W    = 2;
  localparam int ID_W    = 4;
  localparam int DELAY_W = 32;
  localparam int TIME_W  = 60;
  localparam int NEXT_W  = 61;

  localparam logic [NEXT_W-1:0] NEVER_TIME = NEXT_W'(1) << TIME_W;
  localparam logic [TIME_W-1:0] MAX_EXPIRY = {TIME_W{1'b1}};

  localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
  localparam logic [OP_W-1:0] OP_CANCEL = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd2;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [ID_W-1:0]    timer_id;
    logic [DELAY_W-1:0] delay_ms;
    logic [TIME_W-1:0]  now_ms;
  } in_item_t;

  typedef struct packed {
    logic              fired;
    logic [ID_W-1:0]   fired_id;
    logic              error;
    logic [NEXT_W-1:0] next_expiry;
    logic              last;
  } out_item_t;

  typedef struct packed {
    logic latch_in;
    logic create_wr;
    logic set_err;
    logic load_victim;
    logic disarm;
    logic scan_start;
    logic push_fire;
    logic set_earliest;
    logic emit_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    logic            create_ok;
    logic            cancel_ok;
    logic            scan_done;
    logic            best_due;
    logic            fire_full;
    logic            emit_last;
    logic            out_free;
  } dp_stat_t;

endpackage
`default_nettype wire

// ----- design/otq_dp.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// otq_dp: timer queue datapath
// Timer slots, expiry memory, sequential minimum scan, fire buffer and
// result register, all driven by controller commands.
// ---------------------------------------------------------------------------
module otq_dp import otq_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire in_item_t  in_item_i,
  input  wire dp_cmd_t   cmd_i,
  output dp_stat_t       stat_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_item_o
);

  // captured transaction
  logic [OP_W-1:0]    op_q;
  logic [ID_W-1:0]    id_q;
  logic [DELAY_W-1:0] delay_q;
  logic [TIME_W-1:0]  cur_time_q;
  logic               err_q;

  // slot state
  logic [NUM_TIMERS-1:0] armed_q;
  logic [STAMP_W-1:0]    stamp_q [NUM_TIMERS];
  logic [CNT_W-1:0]      stamp_cnt_q;
  logic [TIME_W-1:0]     exp_mem [NUM_TIMERS];

  // scan
  logic               scan_act_q;
  logic [IDX_W-1:0]   scan_issue_q;
  logic               rd_vld_q;
  logic [IDX_W-1:0]   rd_idx_q;
  logic               rd_armed_q;
  logic [STAMP_W-1:0] rd_stamp_q;
  logic [TIME_W-1:0]  rd_exp_q;
  logic               done_q;
  logic               best_valid_q;
  logic [IDX_W-1:0]   best_idx_q;
  logic [STAMP_W-1:0] best_stamp_q;
  logic [TIME_W-1:0]  best_exp_q;
  logic [NEXT_W-1:0]  earliest_q;

  // fire buffer and result
  logic [IDX_W-1:0]   fire_buf_q [MAX_RESULTS];
  logic [RES_W-1:0]   fire_cnt_q;
  logic [RIDX_W-1:0]  emit_idx_q;
  logic               out_valid_q;
  out_item_t          out_q;

  logic [IDX_W-1:0]   id_idx;
  logic               id_ok;
  logic [IDX_W-1:0]   rd_addr;
  logic [NEXT_W-1:0]  sum;
  logic [TIME_W-1:0]  sat_sum;
  logic               take;
  logic               emit_last;

  assign id_idx  = IDX_W'(id_q);
  assign id_ok   = 32'(id_q) < 32'(NUM_TIMERS);
  assign rd_addr = scan_act_q ? scan_issue_q : id_idx;

  // saturate just below never
  assign sum     = {1'b0, cur_time_q} + NEXT_W'(delay_q);
  assign sat_sum = sum[TIME_W] ? MAX_EXPIRY : sum[TIME_W-1:0];

  assign take = rd_armed_q &&
                (!best_valid_q || (rd_exp_q < best_exp_q) ||
                 ((rd_exp_q == best_exp_q) && (rd_stamp_q < best_stamp_q)));

  assign emit_last = (fire_cnt_q == '0) ||
                     (RES_W'(emit_idx_q) == fire_cnt_q - RES_W'(1));

  always_comb begin
    stat_o.op        = op_q;
    stat_o.create_ok = id_ok && !armed_q[id_idx];
    stat_o.cancel_ok = id_ok && armed_q[id_idx];
    stat_o.scan_done = done_q;
    stat_o.best_due  = best_valid_q && (best_exp_q <= cur_time_q);
    stat_o.fire_full = fire_cnt_q == RES_W'(MAX_RESULTS);
    stat_o.emit_last = emit_last;
    stat_o.out_free  = !out_valid_q || out_ready_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q    <= in_item_i.op;
      id_q    <= in_item_i.timer_id;
      delay_q <= in_item_i.delay_ms;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_time_q <= '0;
      err_q      <= 1'b0;
    end else begin
      if (cmd_i.latch_in) begin
        err_q <= 1'b0;
        if (in_item_i.op == OP_TICK) begin
          cur_time_q <= in_item_i.now_ms;
        end
      end else if (cmd_i.set_err) begin
        err_q <= 1'b1;
      end
    end
  end

  // expiry memory: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.create_wr) begin
      exp_mem[id_idx] <= sat_sum;
    end
    rd_exp_q <= exp_mem[rd_addr];
  end

  // creation ranks: close the gap above a disarmed rank
  always_ff @(posedge clk_i) begin
    if (cmd_i.create_wr) begin
      stamp_q[id_idx] <= STAMP_W'(stamp_cnt_q);
    end else if (cmd_i.disarm) begin
      for (int j = 0; j < NUM_TIMERS; j++) begin
        if (armed_q[j] && (stamp_q[j] > best_stamp_q)) begin
          stamp_q[j] <= stamp_q[j] - STAMP_W'(1);
        end
      end
    end
    rd_stamp_q <= stamp_q[rd_addr];
    rd_idx_q   <= rd_addr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q     <= '0;
      stamp_cnt_q <= '0;
      rd_armed_q  <= 1'b0;
    end else begin
      if (cmd_i.create_wr) begin
        armed_q[id_idx] <= 1'b1;
        stamp_cnt_q     <= stamp_cnt_q + CNT_W'(1);
      end else if (cmd_i.disarm) begin
        armed_q[best_idx_q] <= 1'b0;
        if (stamp_cnt_q != '0) begin
          stamp_cnt_q <= stamp_cnt_q - CNT_W'(1);
        end
      end
      rd_armed_q <= armed_q[rd_addr];
    end
  end

  // scan sequencer: one slot issued per cycle, compared in the cycle after its read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_act_q   <= 1'b0;
      scan_issue_q <= '0;
      rd_vld_q     <= 1'b0;
      done_q       <= 1'b0;
    end else begin
      rd_vld_q <= scan_act_q;
      done_q   <= rd_vld_q && (rd_idx_q == IDX_W'(NUM_TIMERS - 1));
      if (cmd_i.scan_start) begin
        scan_act_q   <= 1'b1;
        scan_issue_q <= '0;
      end else if (scan_act_q) begin
        scan_issue_q <= scan_issue_q + IDX_W'(1);
        if (scan_issue_q == IDX_W'(NUM_TIMERS - 1)) begin
          scan_act_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_valid_q <= 1'b0;
    end else begin
      if (cmd_i.scan_start) begin
        best_valid_q <= 1'b0;
      end else if (cmd_i.load_victim) begin
        best_valid_q <= 1'b1;
      end else if (rd_vld_q && take) begin
        best_valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_victim) begin
      best_idx_q   <= id_idx;
      best_stamp_q <= rd_stamp_q;
    end else if (!cmd_i.scan_start && rd_vld_q && take) begin
      best_idx_q   <= rd_idx_q;
      best_stamp_q <= rd_stamp_q;
      best_exp_q   <= rd_exp_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      earliest_q <= NEVER_TIME;
    end else if (cmd_i.set_earliest) begin
      earliest_q <= best_valid_q ? {1'b0, best_exp_q} : NEVER_TIME;
    end
  end

  // fire buffer
  always_ff @(posedge clk_i) begin
    if (cmd_i.push_fire) begin
      fire_buf_q[fire_cnt_q[RIDX_W-1:0]] <= best_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fire_cnt_q <= '0;
      emit_idx_q <= '0;
    end else begin
      if (cmd_i.latch_in) begin
        fire_cnt_q <= '0;
        emit_idx_q <= '0;
      end else begin
        if (cmd_i.push_fire) begin
          fire_cnt_q <= fire_cnt_q + RES_W'(1);
        end
        if (cmd_i.emit_load) begin
          emit_idx_q <= emit_idx_q + RIDX_W'(1);
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_load) begin
      out_q.next_expiry <= earliest_q;
      if (fire_cnt_q == '0) begin
        out_q.fired    <= 1'b0;
        out_q.fired_id <= '0;
        out_q.error    <= err_q;
        out_q.last     <= 1'b1;
      end else begin
        out_q.fired    <= 1'b1;
        out_q.fired_id <= ID_W'(fire_buf_q[emit_idx_q]);
        out_q.error    <= 1'b0;
        out_q.last     <= emit_last;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
`default_nettype wire

// ----- design/otq_ctrl.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// otq_ctrl: timer queue controller
// Sequences create, cancel and tick transactions over the datapath.
// ---------------------------------------------------------------------------
module otq_ctrl import otq_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire dp_stat_t stat_i,
  output dp_cmd_t       cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_CAN_LD,
    ST_CAN_DIS,
    ST_SCAN,
    ST_EMIT
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = state_q == ST_IDLE;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch_in = 1'b1;
          state_d        = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        priority if (stat_i.op == OP_CREATE) begin
          if (stat_i.create_ok) begin
            cmd_o.create_wr  = 1'b1;
            cmd_o.scan_start = 1'b1;
            state_d          = ST_SCAN;
          end else begin
            cmd_o.set_err = 1'b1;
            state_d       = ST_EMIT;
          end
        end else if (stat_i.op == OP_CANCEL) begin
          if (stat_i.cancel_ok) begin
            state_d = ST_CAN_LD;
          end else begin
            state_d = ST_EMIT;
          end
        end else if (stat_i.op == OP_TICK) begin
          cmd_o.scan_start = 1'b1;
          state_d          = ST_SCAN;
        end else begin
          state_d = ST_EMIT;
        end
      end
      ST_CAN_LD: begin
        cmd_o.load_victim = 1'b1;
        state_d           = ST_CAN_DIS;
      end
      ST_CAN_DIS: begin
        cmd_o.disarm     = 1'b1;
        cmd_o.scan_start = 1'b1;
        state_d          = ST_SCAN;
      end
      ST_SCAN: begin
        if (stat_i.scan_done) begin
          if ((stat_i.op == OP_TICK) && stat_i.best_due && !stat_i.fire_full) begin
            // fire the earliest due slot and look again
            cmd_o.push_fire  = 1'b1;
            cmd_o.disarm     = 1'b1;
            cmd_o.scan_start = 1'b1;
          end else begin
            cmd_o.set_earliest = 1'b1;
            state_d            = ST_EMIT;
          end
        end
      end
      ST_EMIT: begin
        if (stat_i.out_free) begin
          cmd_o.emit_load = 1'b1;
          if (stat_i.emit_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule
`default_nettype wire

// ----- design/ordered_timer_expiry_queue_top.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// ordered_timer_expiry_queue_top: one-shot timer queue ordered by expiry
// Usage: send create, cancel or tick transactions on the in channel; take
// result transactions on the out channel. Create and cancel give one result;
// a tick gives one result per fired timer, earliest first, or a single
// non-fired result when nothing is due. The last result of a transaction has
// last set, and every result carries the next pending expiry (2^60 = none).
// Timing: every expiry update runs a sequential scan over all slots, one slot
// per cycle through the expiry memory read port.
// Only one transaction is in work at a time; in_ready_o is high while the
// controller is idle, and the next transaction is taken while the last result
// still sits in the output register.
// Reset: all timers disarmed, time zero, next expiry none; no clearing pass.
// Stall: a held out_ready_i freezes result delivery; nothing is dropped.
// ---------------------------------------------------------------------------
module ordered_timer_expiry_queue_top import otq_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_ready_o,
  input  wire in_item_t in_item_i,
  output logic          out_valid_o,
  input  wire logic     out_ready_i,
  output out_item_t     out_item_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequence the transaction
  otq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // hold slots, scan, and drive results
  otq_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule
`default_nettype wire

// ----- bench/otq_result_checker.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// otq_result_checker: result predictor and scoreboard for the timer queue
// Watches both channels, keeps its own copy of the timer slots and predicts
// the results of every accepted input transaction; each accepted result is
// compared field by field with the oldest prediction.
// ---------------------------------------------------------------------------
module otq_result_checker import otq_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  input  wire logic      in_ready_i,
  input  wire in_item_t  in_item_i,
  input  wire logic      out_valid_i,
  input  wire logic      out_ready_i,
  input  wire out_item_t out_item_i,
  output int             mismatches_o,
  output int             outstanding_o,
  output int             checked_o,
  output int             fired_o
);

  logic              slot_armed  [NUM_TIMERS];
  logic [NEXT_W-1:0] slot_expiry [NUM_TIMERS];
  int                slot_rank   [NUM_TIMERS];
  int                armed_count;
  logic [TIME_W-1:0] now_time;
  logic [NEXT_W-1:0] next_due;

  out_item_t expected_results[$];

  initial begin
    mismatches_o  = 0;
    outstanding_o = 0;
    checked_o     = 0;
    fired_o       = 0;
  end

  task automatic flag_mismatch(input string what);
    mismatches_o++;
    $display("[%0t] MISMATCH: %s", $time, what);
  endtask

  // Earliest expiry wins; ties go to the older creation rank.
  function automatic int first_due_slot();
    int best;
    best = -1;
    for (int s = 0; s < NUM_TIMERS; s++) begin
      if (slot_armed[s]) begin
        if (best < 0 || slot_expiry[s] < slot_expiry[best] ||
            (slot_expiry[s] == slot_expiry[best] && slot_rank[s] < slot_rank[best])) begin
          best = s;
        end
      end
    end
    return best;
  endfunction

  function automatic void refresh_next_due();
    int f;
    f = first_due_slot();
    next_due = (f < 0) ? NEVER_TIME : slot_expiry[f];
  endfunction

  // Disarm a slot and close the gap it leaves in the creation order.
  function automatic void release_slot(int slot);
    int rank;
    rank = slot_rank[slot];
    slot_armed[slot] = 1'b0;
    for (int s = 0; s < NUM_TIMERS; s++) begin
      if (slot_armed[s] && slot_rank[s] > rank) slot_rank[s]--;
    end
    if (armed_count > 0) armed_count--;
  endfunction

  task automatic predict_timer_results(input in_item_t t);
    out_item_t         r;
    logic [NEXT_W-1:0] due;
    int                fired_ids[$];
    int                f;
    r = '0;
    r.last = 1'b1;
    case (t.op)
      OP_CREATE: begin
        r.error = 1'b1;
        if (int'(t.timer_id) < NUM_TIMERS && !slot_armed[t.timer_id]) begin
          due = {1'b0, now_time} + NEXT_W'(t.delay_ms);
          if (due > NEXT_W'(MAX_EXPIRY)) due = NEXT_W'(MAX_EXPIRY);
          slot_armed[t.timer_id]  = 1'b1;
          slot_expiry[t.timer_id] = due;
          slot_rank[t.timer_id]   = armed_count;
          armed_count++;
          refresh_next_due();
          r.error = 1'b0;
        end
      end
      OP_CANCEL: begin
        if (int'(t.timer_id) < NUM_TIMERS && slot_armed[t.timer_id]) begin
          release_slot(int'(t.timer_id));
          refresh_next_due();
        end
      end
      OP_TICK: begin
        now_time = t.now_ms;
        while (fired_ids.size() < MAX_RESULTS) begin
          f = first_due_slot();
          if (f < 0 || slot_expiry[f] > {1'b0, now_time}) break;
          fired_ids.push_back(f);
          release_slot(f);
        end
        refresh_next_due();
      end
      default: ;
    endcase
    r.next_expiry = next_due;
    if (fired_ids.size() == 0) begin
      expected_results.push_back(r);
    end else begin
      foreach (fired_ids[k]) begin
        r.fired    = 1'b1;
        r.fired_id = ID_W'(fired_ids[k]);
        r.last     = (k == fired_ids.size() - 1);
        expected_results.push_back(r);
      end
    end
  endtask

  task automatic compare_result(input out_item_t got);
    out_item_t want;
    if (expected_results.size() == 0) begin
      flag_mismatch($sformatf("result with nothing expected: fired=%0b id=%0d next=%0h",
                              got.fired, got.fired_id, got.next_expiry));
      return;
    end
    want = expected_results.pop_front();
    checked_o++;
    if (want.fired) fired_o++;
    if (got.fired !== want.fired)
      flag_mismatch($sformatf("fired got %0b exp %0b", got.fired, want.fired));
    if (got.fired_id !== want.fired_id)
      flag_mismatch($sformatf("fired_id got %0d exp %0d", got.fired_id, want.fired_id));
    if (got.error !== want.error)
      flag_mismatch($sformatf("error got %0b exp %0b", got.error, want.error));
    if (got.next_expiry !== want.next_expiry)
      flag_mismatch($sformatf("next_expiry got %0h exp %0h",
                              got.next_expiry, want.next_expiry));
    if (got.last !== want.last)
      flag_mismatch($sformatf("last got %0b exp %0b", got.last, want.last));
  endtask

  // Inputs first: a result accepted in the same cycle always belongs to an
  // earlier transaction, so the order only matters for readability.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < NUM_TIMERS; s++) begin
        slot_armed[s]  = 1'b0;
        slot_expiry[s] = '0;
        slot_rank[s]   = 0;
      end
      armed_count = 0;
      now_time    = '0;
      next_due    = NEVER_TIME;
      expected_results.delete();
      outstanding_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) predict_timer_results(in_item_i);
      if (out_valid_i && out_ready_i) compare_result(out_item_i);
      outstanding_o = expected_results.size();
    end
  end

endmodule
`default_nettype wire

// ----- bench/tb_ordered_timer_expiry_queue_top.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// tb_ordered_timer_expiry_queue_top: testbench of the ordered timer queue
// Drives create, cancel, tick and unused-op transactions: a directed opening
// for the corner cases, then random traffic with a burst that fills every slot.
// Both channels idle and stall at random; a checker predicts and compares.
// ---------------------------------------------------------------------------
module tb_ordered_timer_expiry_queue_top import otq_pkg::*; ();

  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  localparam int  RANDOM_ROUNDS = 6;
  localparam int  ROUND_ITEMS   = 20;
  localparam int  DRAIN_CYCLES  = 100;
  // Worst case per transaction is 16 fired timers, each held by a long
  // receiver stall, on top of the scan cycles; allow several times that.
  localparam longint LIMIT_DELAY = 64'd20_000_000;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  int mismatches;
  int outstanding;
  int checked;
  int fired;

  // Stimulus bookkeeping: the time last sent in a tick, a switch for
  // stretches without any idling, and per-op transaction counts.
  logic [TIME_W-1:0] cur_ms;
  bit                calm;
  int n_create, n_cancel, n_tick, n_other;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  ordered_timer_expiry_queue_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  otq_result_checker checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .in_item_i     (in_item),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .out_item_i    (out_item),
    .mismatches_o  (mismatches),
    .outstanding_o (outstanding),
    .checked_o     (checked),
    .fired_o       (fired)
  );

  // Idle length: mostly none or short, now and then a long one.
  function automatic int pick_span();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    return TIME_W'({$urandom, $urandom});
  endfunction

  // Build a transaction; fill the fields the op ignores with random bits.
  function automatic in_item_t make_txn(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                                        logic [DELAY_W-1:0] delay,
                                        logic [TIME_W-1:0] now_ms);
    in_item_t t;
    t.op       = op;
    t.timer_id = id;
    t.delay_ms = delay;
    t.now_ms   = now_ms;
    case (op)
      OP_CREATE: t.now_ms = rand_time();
      OP_CANCEL: begin
        t.delay_ms = $urandom;
        t.now_ms   = rand_time();
      end
      OP_TICK: begin
        t.timer_id = ID_W'($urandom);
        t.delay_ms = $urandom;
      end
      default: ;
    endcase
    return t;
  endfunction

  // Present one transaction and hold it until accepted. Valid only drops
  // for a gap; back-to-back transactions keep it high.
  task automatic send_txn(input in_item_t t);
    int gap;
    gap = calm ? 0 : pick_span();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= t;
    case (t.op)
      OP_CREATE: n_create++;
      OP_CANCEL: n_cancel++;
      OP_TICK:   n_tick++;
      default:   n_other++;
    endcase
    do @(posedge clk); while (!in_ready);
  endtask

  // Hold the sender until every predicted result has been delivered.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    @(posedge clk);
  endtask

  task automatic send_random_txn();
    in_item_t          t;
    int                pick;
    int                sub;
    logic [DELAY_W-1:0] delay;
    pick = $urandom_range(0, 99);
    sub  = $urandom_range(0, 99);
    if (pick < 45) begin
      // Mostly short delays, some near-ties, a few anywhere in range.
      if (sub < 70)      delay = $urandom_range(0, 200);
      else if (sub < 85) delay = $urandom_range(0, 3);
      else               delay = $urandom;
      t = make_txn(OP_CREATE, ID_W'($urandom_range(0, 15)), delay, '0);
    end else if (pick < 60) begin
      t = make_txn(OP_CANCEL, ID_W'($urandom_range(0, 15)), '0, '0);
    end else if (pick < 92) begin
      // Advance time in small steps; sometimes jump anywhere, close to the
      // top of the range, or back toward zero.
      if (sub < 80)      cur_ms = cur_ms + TIME_W'($urandom_range(0, 150));
      else if (sub < 88) cur_ms = rand_time();
      else if (sub < 94) cur_ms = MAX_EXPIRY - TIME_W'($urandom_range(0, 100));
      else               cur_ms = TIME_W'($urandom_range(0, 1000));
      t = make_txn(OP_TICK, '0, '0, cur_ms);
    end else begin
      // Noise: every field random, unused op included.
      t.op       = OP_W'($urandom);
      t.timer_id = ID_W'($urandom);
      t.delay_ms = $urandom;
      t.now_ms   = rand_time();
      if (t.op == OP_TICK) cur_ms = t.now_ms;
    end
    send_txn(t);
  endtask

  // Flush all slots, re-arm every one of them close together, then fire
  // them all with a single tick.
  task automatic send_full_burst();
    send_txn(make_txn(OP_TICK, '0, '0, MAX_EXPIRY));
    cur_ms = TIME_W'($urandom_range(0, 1000));
    send_txn(make_txn(OP_TICK, '0, '0, cur_ms));
    for (int id = 0; id < NUM_TIMERS; id++) begin
      send_txn(make_txn(OP_CREATE, ID_W'(id), $urandom_range(0, 40), '0));
    end
    cur_ms = cur_ms + TIME_W'(40);
    send_txn(make_txn(OP_TICK, '0, '0, cur_ms));
  endtask

  // Receiver: ready in short runs, with stalls of random length; solid
  // ready while the calm stretch is on.
  initial begin : result_sink
    int span;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (calm) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        span = $urandom_range(1, 8);
        repeat (span) @(posedge clk);
        out_ready <= 1'b0;
        span = 1 + pick_span();
        repeat (span) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    #(LIMIT_DELAY);
    $display("Timeout with %0d results still expected", outstanding);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    calm     = 1'b0;
    cur_ms   = '0;
    n_create = 0;
    n_cancel = 0;
    n_tick   = 0;
    n_other  = 0;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_item  <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed opening, time starts at zero.
    send_txn(make_txn(OP_TICK, '0, '0, '0));              // nothing due
    send_txn(make_txn(OP_CANCEL, 4'd5, '0, '0));          // cancel idle slot
    send_txn(make_txn(OP_UNUSED, 4'd15, 32'hFFFF_FFFF, MAX_EXPIRY));
    send_txn(make_txn(OP_CREATE, 4'd0, '0, '0));          // due immediately
    send_txn(make_txn(OP_CREATE, 4'd0, 32'd7, '0));       // already running
    send_txn(make_txn(OP_CREATE, 4'd15, 32'hFFFF_FFFF, '0));
    send_txn(make_txn(OP_CREATE, 4'd9, 32'd5, '0));
    send_txn(make_txn(OP_CREATE, 4'd3, 32'd5, '0));       // tie: 9 goes first
    send_txn(make_txn(OP_CANCEL, 4'd0, '0, '0));          // cancel running
    send_txn(make_txn(OP_TICK, '0, '0, TIME_W'(5)));      // fires 9 then 3
    send_txn(make_txn(OP_TICK, '0, '0, TIME_W'(2)));      // time goes back
    send_txn(make_txn(OP_TICK, '0, '0, MAX_EXPIRY));      // fires 15
    send_txn(make_txn(OP_CREATE, 4'd1, 32'hFFFF_FFFF, '0)); // saturates
    send_txn(make_txn(OP_CREATE, 4'd2, '0, '0));          // ties at the top
    send_txn(make_txn(OP_CREATE, 4'd4, 32'd1, '0));       // saturates too
    send_txn(make_txn(OP_TICK, '0, '0, MAX_EXPIRY));      // fires 1, 2, 4
    send_txn(make_txn(OP_TICK, '0, '0, '0));
    cur_ms = '0;
    wait_results_drained();

    // Random rounds: one without idling, pauses for a full drain, and a
    // burst that fires every slot in one tick.
    for (int round = 0; round < RANDOM_ROUNDS; round++) begin
      calm = (round == 2);
      for (int i = 0; i < ROUND_ITEMS; i++) send_random_txn();
      if (round == 1 || round == 4) wait_results_drained();
      if (round == 3) send_full_burst();
    end
    calm = 1'b0;

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d transactions: %0d create, %0d cancel, %0d tick, %0d unused op",
             n_create + n_cancel + n_tick + n_other, n_create, n_cancel, n_tick, n_other);
    $display("Checked %0d results, %0d of them reporting an expired timer", checked, fired);
    if (mismatches == 0 && outstanding == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
`default_nettype wire
